// File: rtl/sdd_pkg.sv
// shared types, constants and register defaults of the shot dip detector
package sdd_pkg;

    // defaults for the top level parameters
    localparam int SPEED_BITS_DEF     = 16;
    localparam int COOLDOWN_TICKS_DEF = 2;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // configuration port geometry
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RISE_COEFF    = 4'd0,
        CFG_FALL_COEFF    = 4'd1,
        CFG_ARM_DIP_MIN   = 4'd2,
        CFG_ARM_DIP_MAX   = 4'd3,
        CFG_SLOPE_MIN     = 4'd4,
        CFG_RECOVER_LEVEL = 4'd5,
        CFG_SPEED_MIN     = 4'd6,
        CFG_ARMED_TIMEOUT = 4'd7
    } cfg_index_t;

    // register reset values
    localparam logic [15:0] RISE_COEFF_RST    = 16'd44106;
    localparam logic [15:0] FALL_COEFF_RST    = 16'd9306;
    localparam logic [14:0] ARM_DIP_MIN_RST   = 15'd200;
    localparam logic [14:0] ARM_DIP_MAX_RST   = 15'd1200;
    localparam logic [14:0] SLOPE_MIN_RST     = 15'd80;
    localparam logic [14:0] RECOVER_LEVEL_RST = 15'd100;
    localparam logic [14:0] SPEED_MIN_RST     = 15'd4000;
    localparam logic [7:0]  ARMED_TIMEOUT_RST = 8'd14;

    // configuration register set
    typedef struct packed {
        logic [15:0] rise_coeff;
        logic [15:0] fall_coeff;
        logic [14:0] arm_dip_min;
        logic [14:0] arm_dip_max;
        logic [14:0] slope_min;
        logic [14:0] recover_level;
        logic [14:0] speed_min;
        logic [7:0]  armed_timeout;
    } cfg_t;

    // queue handshake between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/sdd_in_if.sv
// sample channel: a pair of signed wheel speeds
interface sdd_in_if #(
    parameter int SPEED_BITS = sdd_pkg::SPEED_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [SPEED_BITS-1:0] speed_left;
    logic signed [SPEED_BITS-1:0] speed_right;

    modport source (output valid, output speed_left, output speed_right, input ready);
    modport sink   (input valid, input speed_left, input speed_right, output ready);
endinterface

// File: rtl/sdd_out_if.sv
// result channel: shot flag and running shot count
interface sdd_out_if;
    logic        valid;
    logic        ready;
    logic        shot_detected;
    logic [15:0] shot_total;

    modport source (output valid, output shot_detected, output shot_total, input ready);
    modport sink   (input valid, input shot_detected, input shot_total, output ready);
endinterface

// File: rtl/shot_dip_detector_top.sv
// top level of the shot dip detector: configuration registers, front, queue, back
//
// Takes one pair of signed wheel speeds per request and returns one result per
// request: a shot flag and the running 16-bit shot count. Sustained rate is one
// request per clock while results are taken; the baseline average (one 17 x
// SPEED_BITS+17 multiply-add in the front) is combinational. A two-entry queue
// between front and back and the output register let either side stall without
// stopping the other. The user must write the configuration registers through
// cfg_we/cfg_index/cfg_data only while no request is in flight; the block does not
// enforce it. Indexes of 8 and above are ignored. No clearing pass follows reset.
module shot_dip_detector_top #(
    parameter int SPEED_BITS     = sdd_pkg::SPEED_BITS_DEF,
    parameter int COOLDOWN_TICKS = sdd_pkg::COOLDOWN_TICKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sdd_in_if.sink                          samples,
    sdd_out_if.source                       results,
    input  logic                            cfg_we,
    input  logic [sdd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sdd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    localparam int ENTRY_W = 3 * SPEED_BITS + 21;

    sdd_pkg::cfg_t          cfg_reg, cfg_next;
    sdd_pkg::queue_status_t status;
    logic                   push, pop;
    logic [ENTRY_W-1:0]     push_data, pop_data;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (sdd_pkg::cfg_index_t'(cfg_index))
                sdd_pkg::CFG_RISE_COEFF:    cfg_next.rise_coeff    = cfg_data[15:0];
                sdd_pkg::CFG_FALL_COEFF:    cfg_next.fall_coeff    = cfg_data[15:0];
                sdd_pkg::CFG_ARM_DIP_MIN:   cfg_next.arm_dip_min   = cfg_data[14:0];
                sdd_pkg::CFG_ARM_DIP_MAX:   cfg_next.arm_dip_max   = cfg_data[14:0];
                sdd_pkg::CFG_SLOPE_MIN:     cfg_next.slope_min     = cfg_data[14:0];
                sdd_pkg::CFG_RECOVER_LEVEL: cfg_next.recover_level = cfg_data[14:0];
                sdd_pkg::CFG_SPEED_MIN:     cfg_next.speed_min     = cfg_data[14:0];
                sdd_pkg::CFG_ARMED_TIMEOUT: cfg_next.armed_timeout = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_coeff    <= sdd_pkg::RISE_COEFF_RST;
            cfg_reg.fall_coeff    <= sdd_pkg::FALL_COEFF_RST;
            cfg_reg.arm_dip_min   <= sdd_pkg::ARM_DIP_MIN_RST;
            cfg_reg.arm_dip_max   <= sdd_pkg::ARM_DIP_MAX_RST;
            cfg_reg.slope_min     <= sdd_pkg::SLOPE_MIN_RST;
            cfg_reg.recover_level <= sdd_pkg::RECOVER_LEVEL_RST;
            cfg_reg.speed_min     <= sdd_pkg::SPEED_MIN_RST;
            cfg_reg.armed_timeout <= sdd_pkg::ARMED_TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: baseline and dip
    sdd_front #(
        .SPEED_BITS (SPEED_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .cfg       (cfg_reg),
        .status    (status),
        .push      (push),
        .push_data (push_data)
    );

    // queue between front and back
    sdd_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (sdd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (status)
    );

    // back: detection and results
    sdd_back #(
        .SPEED_BITS     (SPEED_BITS),
        .COOLDOWN_TICKS (COOLDOWN_TICKS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .status   (status),
        .pop_data (pop_data),
        .pop      (pop),
        .results  (results)
    );

endmodule

// File: rtl/sdd_queue.sv
// short register queue between front and back
module sdd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sdd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      pop_data,
    output sdd_pkg::queue_status_t status
);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    // status and head entry
    assign status.full  = (count_reg == CNTW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/sdd_front.sv
// front: sample magnitude, baseline average, dip and slope
module sdd_front #(
    parameter int SPEED_BITS = sdd_pkg::SPEED_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sdd_in_if.sink                samples,
    input  sdd_pkg::cfg_t         cfg,
    input  sdd_pkg::queue_status_t status,
    output logic                  push,
    output logic [3*SPEED_BITS+20:0] push_data
);
    localparam int V2_W    = SPEED_BITS + 1;
    localparam int BW      = SPEED_BITS + 16;
    localparam int DW      = BW + 1;
    localparam int SL_W    = SPEED_BITS + 2;
    localparam int PW      = BW + 18;

    logic                  seeded_reg, seeded_next;
    logic [BW-1:0]         baseline_reg, baseline_next;
    logic [V2_W-1:0]       prev_reg, prev_next;

    logic [SPEED_BITS-1:0] raw_l, raw_r, mag_l, mag_r;
    logic [V2_W-1:0]       v2;
    logic [BW-1:0]         valq;
    logic [15:0]           coeff;
    logic signed [DW-1:0]  diff;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  rounded;
    logic signed [BW+1:0]  base_sum;
    logic [BW-1:0]         base_new;
    logic signed [DW-1:0]  dip;
    logic signed [SL_W-1:0] slope2;

    // request accepted when the queue has room
    assign samples.ready = !status.full;
    assign push          = samples.valid && !status.full;

    // magnitudes, the most negative code maps to half the range
    always_comb
    begin
        raw_l = samples.speed_left;
        raw_r = samples.speed_right;
        mag_l = raw_l[SPEED_BITS-1] ? (~raw_l + 1'b1) : raw_l;
        mag_r = raw_r[SPEED_BITS-1] ? (~raw_r + 1'b1) : raw_r;
        v2    = {1'b0, mag_l} + {1'b0, mag_r};
        valq  = {v2, 15'd0};
    end

    // baseline step: b + round(c * (val - b) / 2^16), rounding half up
    always_comb
    begin
        coeff    = (valq > baseline_reg) ? cfg.rise_coeff : cfg.fall_coeff;
        diff     = $signed({1'b0, valq}) - $signed({1'b0, baseline_reg});
        prod     = $signed({1'b0, coeff}) * diff;
        rounded  = prod + $signed({{(PW - 17){1'b0}}, 17'h08000});
        base_sum = $signed({2'b00, baseline_reg}) + rounded[PW-1:16];
        base_new = base_sum[BW-1:0];
        dip      = $signed({1'b0, base_new}) - $signed({1'b0, valq});
        slope2   = $signed({1'b0, prev_reg}) - $signed({1'b0, v2});
    end

    // front state; the first sample seeds the baseline
    always_comb
    begin
        seeded_next   = seeded_reg;
        baseline_next = baseline_reg;
        prev_next     = prev_reg;
        if (push)
        begin
            seeded_next   = 1'b1;
            prev_next     = v2;
            baseline_next = seeded_reg ? base_new : valq;
        end
    end

    // queue entry: first flag, doubled speed, slope, dip
    assign push_data = {!seeded_reg, v2, slope2, dip};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg   <= 1'b0;
            baseline_reg <= '0;
            prev_reg     <= '0;
        end
        else
        begin
            seeded_reg   <= seeded_next;
            baseline_reg <= baseline_next;
            prev_reg     <= prev_next;
        end
    end

endmodule

// File: rtl/sdd_back.sv
// back: arm, track deepest dip, count shots, output register
module sdd_back #(
    parameter int SPEED_BITS     = sdd_pkg::SPEED_BITS_DEF,
    parameter int COOLDOWN_TICKS = sdd_pkg::COOLDOWN_TICKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sdd_pkg::cfg_t         cfg,
    input  sdd_pkg::queue_status_t status,
    input  logic [3*SPEED_BITS+20:0] pop_data,
    output logic                  pop,
    sdd_out_if.source             results
);
    localparam int V2_W = SPEED_BITS + 1;
    localparam int BW   = SPEED_BITS + 16;
    localparam int DW   = BW + 1;
    localparam int SL_W = SPEED_BITS + 2;
    localparam int CW   = (DW > 32) ? DW : 32;
    localparam int SCW  = (SL_W > 17) ? SL_W : 17;
    localparam int VCW  = (V2_W > 16) ? V2_W : 16;

    logic                   first;
    logic [V2_W-1:0]        v2;
    logic signed [SL_W-1:0] slope2;
    logic signed [DW-1:0]   dip;

    logic                   armed_reg, armed_next;
    logic [BW-1:0]          deep_reg, deep_next;
    logic [1:0]             cool_reg, cool_next;
    logic [7:0]             ticks_reg, ticks_next;
    logic [15:0]            count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   shot_reg, shot_next;
    logic [15:0]            total_reg, total_next;

    logic signed [CW-1:0]   dip_x, min_x, max_x, rec_x;
    logic signed [SCW-1:0]  slope_x, slope_thr;
    logic [VCW-1:0]         v2_x, speed_thr;
    logic                   arm_ok;
    logic [BW-1:0]          deep_upd;
    logic [DW:0]            deep3;
    logic                   recovered;
    logic [7:0]             ticks_inc;

    // unpack queue entry
    assign {first, v2, slope2, dip} = pop_data;

    // take the head entry when the output register is free or draining
    assign pop = !status.empty && (!out_valid_reg || results.ready);

    // arming and recovery compares
    always_comb
    begin
        dip_x     = $signed({{(CW - DW){dip[DW-1]}}, dip});
        min_x     = $signed({{(CW - 31){1'b0}}, cfg.arm_dip_min, 16'd0});
        max_x     = $signed({{(CW - 31){1'b0}}, cfg.arm_dip_max, 16'd0});
        rec_x     = $signed({{(CW - 31){1'b0}}, cfg.recover_level, 16'd0});
        slope_x   = $signed({{(SCW - SL_W){slope2[SL_W-1]}}, slope2});
        slope_thr = $signed({{(SCW - 16){1'b0}}, cfg.slope_min, 1'b0});
        v2_x      = {{(VCW - V2_W){1'b0}}, v2};
        speed_thr = {{(VCW - 16){1'b0}}, cfg.speed_min, 1'b0};
        arm_ok    = (dip_x > min_x) && (dip_x < max_x) &&
                    (slope_x > slope_thr) && (v2_x > speed_thr);

        deep_upd  = (dip > $signed({1'b0, deep_reg})) ? dip[BW-1:0] : deep_reg;
        deep3     = {2'b00, deep_upd} + {1'b0, deep_upd, 1'b0};
        recovered = ($signed({dip, 2'b00}) < $signed({1'b0, deep3})) ||
                    (dip_x < rec_x);
        ticks_inc = (ticks_reg != 8'hFF) ? (ticks_reg + 8'd1) : ticks_reg;
    end

    // detector state and result
    always_comb
    begin
        armed_next     = armed_reg;
        deep_next      = deep_reg;
        cool_next      = cool_reg;
        ticks_next     = ticks_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        shot_next      = shot_reg;
        total_next     = total_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next = 1'b1;
            shot_next      = 1'b0;
            if (first)
            begin
                deep_next = '0;
                cool_next = '0;
            end
            else if (cool_reg != 2'd0)
            begin
                cool_next  = cool_reg - 2'd1;
                armed_next = 1'b0;
            end
            else if (!armed_reg)
            begin
                if (arm_ok)
                begin
                    armed_next = 1'b1;
                    deep_next  = dip[BW-1:0];
                    ticks_next = '0;
                end
            end
            else
            begin
                ticks_next = ticks_inc;
                deep_next  = deep_upd;
                if (recovered)
                begin
                    armed_next = 1'b0;
                    count_next = count_reg + 16'd1;
                    cool_next  = 2'(COOLDOWN_TICKS);
                    deep_next  = '0;
                    shot_next  = 1'b1;
                end
                else if (ticks_inc >= cfg.armed_timeout)
                begin
                    armed_next = 1'b0;
                    deep_next  = '0;
                end
            end
            total_next = count_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.shot_detected = shot_reg;
    assign results.shot_total    = total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            deep_reg      <= '0;
            cool_reg      <= '0;
            ticks_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            armed_reg     <= armed_next;
            deep_reg      <= deep_next;
            cool_reg      <= cool_next;
            ticks_reg     <= ticks_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        shot_reg  <= shot_next;
        total_reg <= total_next;
    end

endmodule

// File: bench/sdd_shot_checker.sv
// checker of the shot dip detector: predicts every result and compares it
`timescale 1ns / 100ps

module sdd_shot_checker
    import sdd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    sdd_in_if                      samples,
    sdd_out_if                     results,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatch_count,
    output int                     pending_shots
);

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic        shot_detected;
        logic [15:0] shot_total;
    } shot_result_t;

    // mirrored registers and detector state
    cfg_t        cfg_copy;
    logic        seeded_q;
    logic        armed_q;
    logic [31:0] baseline_q;
    logic [16:0] prev_speed_q;
    logic [31:0] deepest_dip_q;
    logic [1:0]  cooldown_q;
    logic [7:0]  armed_ticks_q;
    logic [15:0] shot_count_q;

    shot_result_t expected_shots[$];
    int           result_index;

    // magnitude of a signed speed, doubled scale is kept by the caller
    function automatic logic [16:0] speed_mag(input logic [15:0] raw);
        return raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    endfunction

    // advance the detector by one sample pair and return its result
    function automatic shot_result_t predict_shot(input logic [15:0] left_raw,
                                                  input logic [15:0] right_raw);
        logic [16:0]  speed2;
        logic [31:0]  speed_q;
        logic [15:0]  coeff;
        logic [63:0]  blend;
        longint       prev_l;
        longint       speed2_l;
        longint       speed_ql;
        longint       base_l;
        longint       deep_l;
        longint       slope2;
        longint       dip;
        shot_result_t res;

        speed2  = speed_mag(left_raw) + speed_mag(right_raw);
        speed_q = {speed2, 15'd0};
        res.shot_detected = 1'b0;

        if (!seeded_q)
        begin
            // first sample only seeds the baseline
            baseline_q    = speed_q;
            prev_speed_q  = speed2;
            deepest_dip_q = '0;
            cooldown_q    = '0;
            seeded_q      = 1'b1;
        end
        else
        begin
            prev_l   = prev_speed_q;
            speed2_l = speed2;
            speed_ql = speed_q;
            slope2   = prev_l - speed2_l;
            coeff    = (speed_q > baseline_q) ? cfg_copy.rise_coeff : cfg_copy.fall_coeff;
            prev_speed_q = speed2;

            // asymmetric average, rounded half up
            blend = 64'(coeff) * 64'(speed_q) + (64'd65536 - 64'(coeff)) * 64'(baseline_q)
                    + 64'd32768;
            baseline_q = blend[47:16];
            base_l     = baseline_q;
            dip        = base_l - speed_ql;
            deep_l     = deepest_dip_q;

            if (cooldown_q != '0)
            begin
                cooldown_q = cooldown_q - 2'd1;
                armed_q    = 1'b0;
            end
            else if (!armed_q)
            begin
                // arm on a moderate, steep dip at high speed
                if (dip > (longint'(cfg_copy.arm_dip_min) <<< 16) &&
                    dip < (longint'(cfg_copy.arm_dip_max) <<< 16) &&
                    slope2 > 2 * longint'(cfg_copy.slope_min) &&
                    speed2_l > 2 * longint'(cfg_copy.speed_min))
                begin
                    armed_q       = 1'b1;
                    deepest_dip_q = dip[31:0];
                    armed_ticks_q = '0;
                end
            end
            else
            begin
                if (armed_ticks_q != 8'hFF)
                    armed_ticks_q = armed_ticks_q + 8'd1;
                if (dip > deep_l)
                begin
                    deepest_dip_q = dip[31:0];
                    deep_l        = dip;
                end
                // recovery past three quarters of the deepest dip or below the level
                if (4 * dip < 3 * deep_l || dip < (longint'(cfg_copy.recover_level) <<< 16))
                begin
                    armed_q           = 1'b0;
                    shot_count_q      = shot_count_q + 16'd1;
                    cooldown_q        = 2'(COOLDOWN_TICKS_DEF);
                    deepest_dip_q     = '0;
                    res.shot_detected = 1'b1;
                end
                else if (armed_ticks_q >= cfg_copy.armed_timeout)
                begin
                    armed_q       = 1'b0;
                    deepest_dip_q = '0;
                end
            end
        end

        res.shot_total = shot_count_q;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d: %s", result_index, msg);
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        shot_result_t want;

        if (!rst_n)
        begin
            cfg_copy.rise_coeff    = RISE_COEFF_RST;
            cfg_copy.fall_coeff    = FALL_COEFF_RST;
            cfg_copy.arm_dip_min   = ARM_DIP_MIN_RST;
            cfg_copy.arm_dip_max   = ARM_DIP_MAX_RST;
            cfg_copy.slope_min     = SLOPE_MIN_RST;
            cfg_copy.recover_level = RECOVER_LEVEL_RST;
            cfg_copy.speed_min     = SPEED_MIN_RST;
            cfg_copy.armed_timeout = ARMED_TIMEOUT_RST;
            seeded_q       = 1'b0;
            armed_q        = 1'b0;
            baseline_q     = '0;
            prev_speed_q   = '0;
            deepest_dip_q  = '0;
            cooldown_q     = '0;
            armed_ticks_q  = '0;
            shot_count_q   = '0;
            expected_shots.delete();
            result_index   = 0;
            mismatch_count = 0;
            pending_shots  = 0;
        end
        else
        begin
            // compare an accepted result with the oldest prediction
            if (results.valid && results.ready)
            begin
                if (expected_shots.size() == 0)
                    report_mismatch($sformatf("unexpected result shot_detected=%0b total=%0d",
                                              results.shot_detected, results.shot_total));
                else
                begin
                    want = expected_shots.pop_front();
                    if (results.shot_detected !== want.shot_detected)
                        report_mismatch($sformatf("shot_detected is %0b, expected %0b",
                                                  results.shot_detected, want.shot_detected));
                    if (results.shot_total !== want.shot_total)
                        report_mismatch($sformatf("shot_total is %0d, expected %0d",
                                                  results.shot_total, want.shot_total));
                end
                result_index++;
            end

            // predict for an accepted request
            if (samples.valid && samples.ready)
                expected_shots.push_back(predict_shot(samples.speed_left, samples.speed_right));

            // mirror register writes, unused indexes change nothing
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RISE_COEFF:    cfg_copy.rise_coeff    = cfg_data[15:0];
                    CFG_FALL_COEFF:    cfg_copy.fall_coeff    = cfg_data[15:0];
                    CFG_ARM_DIP_MIN:   cfg_copy.arm_dip_min   = cfg_data[14:0];
                    CFG_ARM_DIP_MAX:   cfg_copy.arm_dip_max   = cfg_data[14:0];
                    CFG_SLOPE_MIN:     cfg_copy.slope_min     = cfg_data[14:0];
                    CFG_RECOVER_LEVEL: cfg_copy.recover_level = cfg_data[14:0];
                    CFG_SPEED_MIN:     cfg_copy.speed_min     = cfg_data[14:0];
                    CFG_ARMED_TIMEOUT: cfg_copy.armed_timeout = cfg_data[7:0];
                    default: ;
                endcase
            end

            pending_shots = expected_shots.size();
        end
    end

endmodule

// File: bench/tb_shot_dip_detector_top.sv
// testbench top of the shot dip detector: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_shot_dip_detector_top;
    import sdd_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 10;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_ITEMS      = 110;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_PHASE       = 4;
    localparam int NOISE_SPREAD     = 20;
    localparam int MAX_MAG          = 32767;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_BASE = CFG_INDEX_W'(8);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatch_count;
    int                     pending_shots;
    int                     cycle_count = 0;
    int                     sender_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     hold_left = 0;
    int                     items_sent = 0;
    cfg_t                   cur_cfg;

    sdd_in_if #(.SPEED_BITS(SPEED_BITS_DEF)) sample_ch ();
    sdd_out_if                               result_ch ();

    shot_dip_detector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdd_shot_checker u_shot_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (sample_ch),
        .results        (result_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending_shots  (pending_shots)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                result_ch.ready <= (int'($urandom_range(0, 99)) >= recv_idle_pct);
        end
    end

    function automatic int clamp_speed(input int mag);
        if (mag < 0)
            return 0;
        if (mag > MAX_MAG)
            return MAX_MAG;
        return mag;
    endfunction

    // one request on the sample channel, with random sender gaps
    task automatic send_sample(input int left, input int right);
        while (int'($urandom_range(0, 99)) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.speed_left  <= 16'(left);
        sample_ch.speed_right <= 16'(right);
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // a pair around a given mean speed, signs chosen at random
    task automatic send_level(input int mean);
        int spread;
        int mag_l;
        int mag_r;
        spread = int'($urandom_range(0, 2 * NOISE_SPREAD)) - NOISE_SPREAD;
        mag_l  = clamp_speed(mean + spread);
        mag_r  = clamp_speed(mean - spread);
        send_sample($urandom_range(0, 1) ? -mag_l : mag_l,
                    $urandom_range(0, 1) ? -mag_r : mag_r);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // write every register, with junk in the unused upper data bits
    task automatic load_config(input cfg_t c);
        put_reg(CFG_RISE_COEFF, c.rise_coeff);
        put_reg(CFG_FALL_COEFF, c.fall_coeff);
        put_reg(CFG_ARM_DIP_MIN, {1'($urandom_range(0, 1)), c.arm_dip_min});
        put_reg(CFG_ARM_DIP_MAX, {1'($urandom_range(0, 1)), c.arm_dip_max});
        put_reg(CFG_SLOPE_MIN, {1'($urandom_range(0, 1)), c.slope_min});
        put_reg(CFG_RECOVER_LEVEL, {1'($urandom_range(0, 1)), c.recover_level});
        put_reg(CFG_SPEED_MIN, {1'($urandom_range(0, 1)), c.speed_min});
        put_reg(CFG_ARMED_TIMEOUT, {8'($urandom_range(0, 255)), c.armed_timeout});
        // an unused index must leave every register alone
        put_reg(CFG_UNUSED_BASE + CFG_INDEX_W'($urandom_range(0, 7)), 16'($urandom()));
        cfg_we <= 1'b0;
    endtask

    // stop offering and wait for every predicted result
    task automatic finish_phase();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_shots != 0);
    endtask

    // stimulus and verdict
    initial
    begin
        int         phase_start;
        int         level;
        int         low;
        int         lo_level;
        int         hi_level;
        int         drop_lo;
        int         drop_hi;
        idle_mode_t mode;

        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.speed_left  = '0;
        sample_ch.speed_right = '0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        cur_cfg.rise_coeff    = RISE_COEFF_RST;
        cur_cfg.fall_coeff    = FALL_COEFF_RST;
        cur_cfg.arm_dip_min   = ARM_DIP_MIN_RST;
        cur_cfg.arm_dip_max   = ARM_DIP_MAX_RST;
        cur_cfg.slope_min     = SLOPE_MIN_RST;
        cur_cfg.recover_level = RECOVER_LEVEL_RST;
        cur_cfg.speed_min     = SPEED_MIN_RST;
        cur_cfg.armed_timeout = ARMED_TIMEOUT_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: seed, steady speed, one shot, cooldown, field extremes
        repeat (6) send_sample(6000, -6000);
        send_sample(5500, 5500);
        send_sample(-5300, 5300);
        send_sample(5900, -5900);
        // steep dip during cooldown is ignored
        send_sample(5400, 5400);
        send_sample(6000, 6000);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(0, -1);
        send_sample(-1, 0);
        send_sample(-32768, -32768);
        finish_phase();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // register setting of this phase
            case (phase)
                3:
                begin
                    cur_cfg = '0;
                end
                5:
                begin
                    cur_cfg.rise_coeff    = 16'hFFFF;
                    cur_cfg.fall_coeff    = 16'hFFFF;
                    cur_cfg.arm_dip_min   = 15'h7FFF;
                    cur_cfg.arm_dip_max   = 15'h7FFF;
                    cur_cfg.slope_min     = 15'h7FFF;
                    cur_cfg.recover_level = 15'h7FFF;
                    cur_cfg.speed_min     = 15'h7FFF;
                    cur_cfg.armed_timeout = 8'hFF;
                end
                6:
                begin
                    // thresholds wide open, fastest rise and frozen fall
                    cur_cfg.rise_coeff    = 16'hFFFF;
                    cur_cfg.fall_coeff    = 16'h0000;
                    cur_cfg.arm_dip_min   = 15'h0000;
                    cur_cfg.arm_dip_max   = 15'h7FFF;
                    cur_cfg.slope_min     = 15'h0000;
                    cur_cfg.recover_level = 15'h0000;
                    cur_cfg.speed_min     = 15'h0000;
                    cur_cfg.armed_timeout = 8'd1;
                end
                7:
                begin
                    cur_cfg.rise_coeff    = RISE_COEFF_RST;
                    cur_cfg.fall_coeff    = FALL_COEFF_RST;
                    cur_cfg.arm_dip_min   = ARM_DIP_MIN_RST;
                    cur_cfg.arm_dip_max   = ARM_DIP_MAX_RST;
                    cur_cfg.slope_min     = SLOPE_MIN_RST;
                    cur_cfg.recover_level = RECOVER_LEVEL_RST;
                    cur_cfg.speed_min     = SPEED_MIN_RST;
                    cur_cfg.armed_timeout = ARMED_TIMEOUT_RST;
                end
                default:
                begin
                    cur_cfg.rise_coeff    = 16'($urandom_range(20000, 65535));
                    cur_cfg.fall_coeff    = 16'($urandom_range(2000, 30000));
                    cur_cfg.arm_dip_min   = 15'($urandom_range(50, 400));
                    cur_cfg.arm_dip_max   = cur_cfg.arm_dip_min
                                            + 15'($urandom_range(300, 2000));
                    cur_cfg.slope_min     = 15'($urandom_range(20, 200));
                    cur_cfg.recover_level = 15'($urandom_range(20, 300));
                    cur_cfg.speed_min     = 15'($urandom_range(1000, 8000));
                    cur_cfg.armed_timeout = 8'($urandom_range(1, 30));
                end
            endcase
            load_config(cur_cfg);

            // idling of this phase
            mode = idle_mode_t'(phase % 4);
            case (mode)
                IDLE_SENDER:
                begin
                    sender_idle_pct = 50;
                    recv_idle_pct   = 0;
                end
                IDLE_RECEIVER:
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 50;
                end
                IDLE_BOTH:
                begin
                    sender_idle_pct = 6;
                    recv_idle_pct   = 6;
                end
                default:
                begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase
            // receiver holds off while requests keep coming, so the block backs up
            if (phase == HOLD_PHASE)
                hold_left = LONG_HOLD_CYCLES;

            // speed profiles shaped by the current thresholds
            lo_level = int'(cur_cfg.speed_min) + 200;
            if (lo_level > 30000)
                lo_level = 30000;
            hi_level = lo_level + 8000;
            if (hi_level > 32000)
                hi_level = 32000;
            drop_lo = int'(cur_cfg.arm_dip_min);
            drop_hi = int'(cur_cfg.arm_dip_max) + int'(cur_cfg.arm_dip_max) / 4 + 20;

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                level = int'($urandom_range(lo_level, hi_level));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        // steady, sudden dip, deepen, then some recovery
                        repeat ($urandom_range(3, 8)) send_level(level);
                        low = level - int'($urandom_range(drop_lo, drop_hi));
                        send_level(low);
                        repeat ($urandom_range(0, 3))
                        begin
                            low -= int'($urandom_range(0, 250));
                            send_level(low);
                        end
                        case ($urandom_range(0, 2))
                            0: send_level(level);
                            1: send_level(low + (level - low) * int'($urandom_range(30, 60)) / 100);
                            default: send_level(low);
                        endcase
                        repeat ($urandom_range(2, 5)) send_level(level);
                    end
                    6, 7:
                    begin
                        // dip followed by a slow slide, runs into the timeout
                        repeat ($urandom_range(3, 8)) send_level(level);
                        low = level - int'($urandom_range(drop_lo, drop_hi));
                        send_level(low);
                        repeat ($urandom_range(5, 35))
                        begin
                            low -= int'($urandom_range(30, 120));
                            send_level(low);
                        end
                        send_level(level);
                    end
                    default:
                    begin
                        // full range noise
                        repeat ($urandom_range(1, 4))
                            send_sample(int'($urandom_range(0, 65535)) - 32768,
                                        int'($urandom_range(0, 65535)) - 32768);
                    end
                endcase
            end
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_shots == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
